// File: rtl/xmcrc_pkg.sv
// package: codes, result type and crc helper for the xmodem crc receiver
`default_nettype none

package xmcrc_pkg;

    localparam int MAX_BLOCK_BYTES = 1024;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_AW         = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW         = $clog2(FIFO_DEPTH + 1);

    // input kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    // result kinds
    localparam logic [1:0] OK_TX     = 2'd0;
    localparam logic [1:0] OK_DATA   = 2'd1;
    localparam logic [1:0] OK_COMMIT = 2'd2;
    localparam logic [1:0] OK_STATUS = 2'd3;

    // run status
    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // protocol bytes
    localparam logic [7:0] CH_SOH  = 8'h01;
    localparam logic [7:0] CH_STX  = 8'h02;
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_ACK  = 8'h06;
    localparam logic [7:0] CH_NAK  = 8'h15;
    localparam logic [7:0] CH_CAN  = 8'h18;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [10:0] LEN_SHORT = 11'd128;
    localparam logic [10:0] LEN_LONG  = 11'd1024;

    // register indexes
    localparam logic [2:0] REG_BLOCK_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_START_RETRY   = 3'd1;
    localparam logic [2:0] REG_START_LIMIT   = 3'd2;
    localparam logic [2:0] REG_BLOCK_LIMIT   = 3'd3;
    localparam logic [2:0] REG_SLOT_SIZE     = 3'd4;
    localparam logic [2:0] REG_ALLOW_LONG    = 3'd5;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_HEADER = 3'd1,
        PH_BLKNUM = 3'd2,
        PH_BLKINV = 3'd3,
        PH_DATA   = 3'd4
    } phase_t;

    // what one item reports
    typedef enum logic [2:0] {
        EV_NONE,
        EV_C,
        EV_DATA,
        EV_ACK,
        EV_COMMIT,
        EV_NAK,
        EV_CAN
    } event_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [9:0]  idx;
        logic [15:0] off;
        logic [10:0] len;
        logic [1:0]  status;
        logic        last;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic result_t make_res(input logic [1:0] k, input logic [7:0] d,
                                         input logic [9:0] idx, input logic [15:0] off,
                                         input logic [10:0] len);
        result_t r;
        r.kind   = k;
        r.data   = d;
        r.idx    = idx;
        r.off    = off;
        r.len    = len;
        r.status = ST_BUSY;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/xmodem_crc_receiver_core.sv
// top level: xmodem crc receiver protocol engine with result queue
//
// channel   dir  beat contents
// s_axis    in   tuser = kind, tdata = rx_byte
// m_axis    out  tuser = out_kind, tdata = byte/index/offset/length/status, tlast = last
// cfg       in   cfg_we writes cfg_data into register cfg_index, no read-back
//
// one input beat per cycle while the queue has room; a beat is registered, then the phase logic
// and the byte-wide crc update run combinationally and push up to two results into a four-entry
// queue; the first result is offered once its beat has passed the input register and the queue
// write; items giving two results are paced by the output port, which moves one beat per cycle
// while m_axis_tready is high
// input is taken while the input stage is empty or the queue has room for two more results
// rst_n clears all control state and loads the register defaults
`default_nettype none

module xmodem_crc_receiver_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [7:0] out_byte, [17:8] stage_index,
                                             // [33:18] store_offset, [44:34] store_length,
                                             // [46:45] run_status, [47] zero
    output logic [1:0]       m_axis_tuser,   // [1:0] out_kind
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // configuration
    logic [7:0]  block_timeout_reg;
    logic [7:0]  start_retry_reg;
    logic [7:0]  start_limit_reg;
    logic [7:0]  block_limit_reg;
    logic [15:0] capacity_reg;
    logic        allow_long_reg;

    // input stage
    logic        in_valid_reg;
    logic [1:0]  in_kind_reg;
    logic [7:0]  in_byte_reg;

    // protocol state
    xmcrc_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  exp_reg, exp_next;
    logic [7:0]  bnum_reg, bnum_next;
    logic [7:0]  binv_reg, binv_next;
    logic        long_reg, long_next;
    logic [10:0] bidx_reg, bidx_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic [7:0]  sec_reg, sec_next;
    logic [7:0]  hs_reg, hs_next;
    logic [7:0]  rc_reg, rc_next;
    logic [15:0] sp_reg, sp_next;

    // result queue
    xmcrc_pkg::result_t fifo_mem_reg [xmcrc_pkg::FIFO_DEPTH];
    logic [xmcrc_pkg::FIFO_AW-1:0] head_reg, tail_reg;
    logic [xmcrc_pkg::FIFO_CW-1:0] count_reg;

    logic        proc_fire;
    logic        pop;
    logic [1:0]  push_n;
    logic [10:0] blk_len;
    xmcrc_pkg::event_t  ev;
    xmcrc_pkg::result_t res_a, res_b;

    assign proc_fire     = in_valid_reg &&
                           (count_reg <= xmcrc_pkg::FIFO_CW'(xmcrc_pkg::FIFO_DEPTH - 2));
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign blk_len       = long_reg ? xmcrc_pkg::LEN_LONG : xmcrc_pkg::LEN_SHORT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_timeout_reg <= 8'd3;
            start_retry_reg   <= 8'd3;
            start_limit_reg   <= 8'd20;
            block_limit_reg   <= 8'd10;
            capacity_reg      <= 16'd32768;
            allow_long_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                xmcrc_pkg::REG_BLOCK_TIMEOUT: block_timeout_reg <= cfg_data[7:0];
                xmcrc_pkg::REG_START_RETRY:   start_retry_reg   <= cfg_data[7:0];
                xmcrc_pkg::REG_START_LIMIT:   start_limit_reg   <= cfg_data[7:0];
                xmcrc_pkg::REG_BLOCK_LIMIT:   block_limit_reg   <= cfg_data[7:0];
                xmcrc_pkg::REG_SLOT_SIZE:     capacity_reg      <= cfg_data;
                xmcrc_pkg::REG_ALLOW_LONG:    allow_long_reg    <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    // phase logic for one item
    always_comb
    begin
        logic        do_retry;
        logic        do_cancel;
        logic [7:0]  c;
        logic [7:0]  sec_inc;
        logic [7:0]  cnt_inc;
        logic [15:0] rcrc_full;
        logic [16:0] sp_end;

        ev        = xmcrc_pkg::EV_NONE;
        do_retry  = 1'b0;
        do_cancel = 1'b0;
        c         = in_byte_reg;
        sec_inc   = (sec_reg == 8'hFF) ? sec_reg : sec_reg + 8'd1;
        cnt_inc   = 8'd0;
        rcrc_full = {rcrc_reg[15:8], c};
        sp_end    = {1'b0, sp_reg} + {6'd0, blk_len};

        phase_next  = phase_reg;
        status_next = status_reg;
        exp_next    = exp_reg;
        bnum_next   = bnum_reg;
        binv_next   = binv_reg;
        long_next   = long_reg;
        bidx_next   = bidx_reg;
        crc_next    = crc_reg;
        rcrc_next   = rcrc_reg;
        sec_next    = sec_reg;
        hs_next     = hs_reg;
        rc_next     = rc_reg;
        sp_next     = sp_reg;

        if (in_kind_reg == xmcrc_pkg::KIND_NOP)
        begin
            ev = xmcrc_pkg::EV_NONE;
        end
        else if (in_kind_reg == xmcrc_pkg::KIND_START)
        begin
            exp_next    = 8'd1;
            rc_next     = 8'd0;
            bidx_next   = 11'd0;
            sp_next     = 16'd0;
            phase_next  = xmcrc_pkg::PH_START;
            sec_next    = 8'd0;
            hs_next     = 8'd1;
            if (start_limit_reg <= 8'd1)
                status_next = xmcrc_pkg::ST_ERR;
            else
            begin
                status_next = xmcrc_pkg::ST_BUSY;
                ev          = xmcrc_pkg::EV_C;
            end
        end
        else if (status_reg != xmcrc_pkg::ST_BUSY)
        begin
            // finished: the status-only result is added below
            ev = xmcrc_pkg::EV_NONE;
        end
        else if (in_kind_reg == xmcrc_pkg::KIND_BYTE)
        begin
            unique case (phase_reg)
                xmcrc_pkg::PH_START:
                begin
                    if (c == xmcrc_pkg::CH_SOH || c == xmcrc_pkg::CH_STX)
                    begin
                        long_next  = (c == xmcrc_pkg::CH_STX);
                        bidx_next  = 11'd0;
                        phase_next = xmcrc_pkg::PH_BLKNUM;
                        sec_next   = 8'd0;
                    end
                    else if (c == xmcrc_pkg::CH_CAN)
                        status_next = xmcrc_pkg::ST_ERR;
                end
                xmcrc_pkg::PH_HEADER:
                begin
                    if (c == xmcrc_pkg::CH_EOT)
                    begin
                        ev          = xmcrc_pkg::EV_ACK;
                        status_next = xmcrc_pkg::ST_OK;
                    end
                    else if (c == xmcrc_pkg::CH_CAN)
                        status_next = xmcrc_pkg::ST_ERR;
                    else if (c == xmcrc_pkg::CH_SOH || c == xmcrc_pkg::CH_STX)
                    begin
                        long_next  = (c == xmcrc_pkg::CH_STX);
                        bidx_next  = 11'd0;
                        phase_next = xmcrc_pkg::PH_BLKNUM;
                        sec_next   = 8'd0;
                    end
                    else
                        do_retry = 1'b1;
                end
                xmcrc_pkg::PH_BLKNUM:
                begin
                    bnum_next  = c;
                    phase_next = xmcrc_pkg::PH_BLKINV;
                    sec_next   = 8'd0;
                end
                xmcrc_pkg::PH_BLKINV:
                begin
                    binv_next = c;
                    if (long_reg && !(allow_long_reg && xmcrc_pkg::MAX_BLOCK_BYTES >= 1024))
                        do_retry = 1'b1;
                    else
                    begin
                        phase_next = xmcrc_pkg::PH_DATA;
                        sec_next   = 8'd0;
                        bidx_next  = 11'd0;
                        crc_next   = 16'd0;
                    end
                end
                default:
                begin
                    // data bytes, then crc high and low
                    sec_next  = 8'd0;
                    bidx_next = bidx_reg + 11'd1;
                    if (bidx_reg < blk_len)
                    begin
                        crc_next = xmcrc_pkg::crc_byte(crc_reg, c);
                        ev       = xmcrc_pkg::EV_DATA;
                    end
                    else if (bidx_reg == blk_len)
                        rcrc_next = {c, 8'h00};
                    else
                    begin
                        rcrc_next = rcrc_full;
                        if ((bnum_reg + binv_reg) != 8'hFF || crc_reg != rcrc_full)
                            do_retry = 1'b1;
                        else if (bnum_reg == exp_reg)
                        begin
                            if (sp_end > {1'b0, capacity_reg})
                                do_cancel = 1'b1;
                            else
                            begin
                                ev         = xmcrc_pkg::EV_COMMIT;
                                sp_next    = sp_end[15:0];
                                exp_next   = exp_reg + 8'd1;
                                rc_next    = 8'd0;
                                phase_next = xmcrc_pkg::PH_HEADER;
                                sec_next   = 8'd0;
                            end
                        end
                        else if (bnum_reg == exp_reg - 8'd1)
                        begin
                            // duplicate of the last block
                            ev         = xmcrc_pkg::EV_ACK;
                            rc_next    = 8'd0;
                            phase_next = xmcrc_pkg::PH_HEADER;
                            sec_next   = 8'd0;
                        end
                        else
                            do_cancel = 1'b1;
                    end
                end
            endcase
        end
        else
        begin
            sec_next = sec_inc;
            if (phase_reg == xmcrc_pkg::PH_START)
            begin
                if (sec_inc >= start_retry_reg)
                begin
                    cnt_inc = (hs_reg == 8'hFF) ? hs_reg : hs_reg + 8'd1;
                    hs_next = cnt_inc;
                    if (cnt_inc >= start_limit_reg)
                        status_next = xmcrc_pkg::ST_ERR;
                    else
                    begin
                        ev       = xmcrc_pkg::EV_C;
                        sec_next = 8'd0;
                    end
                end
            end
            else if (sec_inc >= block_timeout_reg)
                do_retry = 1'b1;
        end

        if (do_retry)
        begin
            bidx_next = 11'd0;
            cnt_inc   = (rc_reg == 8'hFF) ? rc_reg : rc_reg + 8'd1;
            rc_next   = cnt_inc;
            if (cnt_inc >= block_limit_reg)
                status_next = xmcrc_pkg::ST_ERR;
            else
            begin
                ev         = xmcrc_pkg::EV_NAK;
                phase_next = xmcrc_pkg::PH_HEADER;
                sec_next   = 8'd0;
            end
        end

        if (do_cancel)
        begin
            ev          = xmcrc_pkg::EV_CAN;
            status_next = xmcrc_pkg::ST_ERR;
        end
    end

    // results for one item
    always_comb
    begin
        logic [1:0] n;

        res_a = xmcrc_pkg::make_res(xmcrc_pkg::OK_STATUS, 8'd0, 10'd0, 16'd0, 11'd0);
        res_b = res_a;
        n     = 2'd1;
        unique case (ev)
            xmcrc_pkg::EV_C:
                res_a = xmcrc_pkg::make_res(xmcrc_pkg::OK_TX, xmcrc_pkg::CH_C,
                                            10'd0, 16'd0, 11'd0);
            xmcrc_pkg::EV_DATA:
                res_a = xmcrc_pkg::make_res(xmcrc_pkg::OK_DATA, in_byte_reg, bidx_reg[9:0],
                                            16'd0, 11'd0);
            xmcrc_pkg::EV_ACK:
                res_a = xmcrc_pkg::make_res(xmcrc_pkg::OK_TX, xmcrc_pkg::CH_ACK,
                                            10'd0, 16'd0, 11'd0);
            xmcrc_pkg::EV_NAK:
                res_a = xmcrc_pkg::make_res(xmcrc_pkg::OK_TX, xmcrc_pkg::CH_NAK,
                                            10'd0, 16'd0, 11'd0);
            xmcrc_pkg::EV_COMMIT:
            begin
                res_a = xmcrc_pkg::make_res(xmcrc_pkg::OK_COMMIT, 8'd0, 10'd0, sp_reg,
                                            blk_len);
                res_b = xmcrc_pkg::make_res(xmcrc_pkg::OK_TX, xmcrc_pkg::CH_ACK,
                                            10'd0, 16'd0, 11'd0);
                n     = 2'd2;
            end
            xmcrc_pkg::EV_CAN:
            begin
                res_a = xmcrc_pkg::make_res(xmcrc_pkg::OK_TX, xmcrc_pkg::CH_CAN,
                                            10'd0, 16'd0, 11'd0);
                res_b = res_a;
                n     = 2'd2;
            end
            default:
                // a no-op beat never reports, even after the run has finished
                n = (status_next != xmcrc_pkg::ST_BUSY &&
                     in_kind_reg != xmcrc_pkg::KIND_NOP) ? 2'd1 : 2'd0;
        endcase

        res_a.status = status_next;
        res_b.status = status_next;
        res_a.last   = (n == 2'd1);
        res_b.last   = 1'b1;
        push_n       = proc_fire ? n : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= xmcrc_pkg::PH_START;
            status_reg <= xmcrc_pkg::ST_ERR;
            exp_reg    <= 8'd1;
            bnum_reg   <= 8'd0;
            binv_reg   <= 8'd0;
            long_reg   <= 1'b0;
            bidx_reg   <= 11'd0;
            crc_reg    <= 16'd0;
            rcrc_reg   <= 16'd0;
            sec_reg    <= 8'd0;
            hs_reg     <= 8'd0;
            rc_reg     <= 8'd0;
            sp_reg     <= 16'd0;
        end
        else if (proc_fire)
        begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            exp_reg    <= exp_next;
            bnum_reg   <= bnum_next;
            binv_reg   <= binv_next;
            long_reg   <= long_next;
            bidx_reg   <= bidx_next;
            crc_reg    <= crc_next;
            rcrc_reg   <= rcrc_next;
            sec_reg    <= sec_next;
            hs_reg     <= hs_next;
            rc_reg     <= rc_next;
            sp_reg     <= sp_next;
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_mem_reg[tail_reg] <= res_a;
        if (push_n == 2'd2)
            fifo_mem_reg[tail_reg + xmcrc_pkg::FIFO_AW'(1)] <= res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            tail_reg  <= tail_reg + xmcrc_pkg::FIFO_AW'(push_n);
            head_reg  <= head_reg + xmcrc_pkg::FIFO_AW'(pop);
            count_reg <= count_reg + xmcrc_pkg::FIFO_CW'(push_n) - xmcrc_pkg::FIFO_CW'(pop);
        end
    end

    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tuser  = fifo_mem_reg[head_reg].kind;
    assign m_axis_tlast  = fifo_mem_reg[head_reg].last;
    assign m_axis_tdata  = {1'b0,
                            fifo_mem_reg[head_reg].status,
                            fifo_mem_reg[head_reg].len,
                            fifo_mem_reg[head_reg].off,
                            fifo_mem_reg[head_reg].idx,
                            fifo_mem_reg[head_reg].data};

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= xmcrc_pkg::FIFO_CW'(xmcrc_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // a commit is always followed by its ack in the same item
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == xmcrc_pkg::OK_COMMIT |-> !m_axis_tlast)
        else $error("commit marked as final result");

    // byte position stays within block plus two crc bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        bidx_reg <= 11'(xmcrc_pkg::MAX_BLOCK_BYTES + 2))
        else $error("byte index out of range");

    // a held item in the input stage keeps waiting until the queue has room for two more results
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !proc_fire |=> in_valid_reg)
        else $error("input item dropped");

endmodule

`default_nettype wire
